// File: design/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// Circle pair collision resolve: shared types and helpers
// Status codes, register indexes, the pipeline work record and the
// saturating adder used by the final stage.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_RESOLVED   = 2'd1,
        ST_SEPARATING = 2'd2,
        ST_COINCIDENT = 2'd3
    } t_status;

    typedef enum logic {
        CFG_PCT  = 1'b0,
        CFG_SLOP = 1'b1
    } t_cfg_idx;

    localparam int NORM_BITS = 28;
    localparam int PCT_BITS  = 16;
    localparam logic [15:0] PCT_RST = 16'd52429;

    typedef struct packed {
        logic signed [31:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic signed [32:0] dx, dy;
        logic [31:0]        ax, ay;
        logic signed [32:0] rvx, rvy;
        logic [31:0]        min_dist;
        logic [15:0]        w1, w2;
        logic [16:0]        wsum;
        logic [63:0]        sx, sy, md2, d2;
        t_status            status;
        logic [33:0]        srem;
        logic [31:0]        sroot;
        logic [31:0]        xrem, yrem;
        logic [31:0]        xnum, ynum;
        logic [31:0]        xq, yq;
        logic signed [62:0] px, py;
        logic [33:0]        dmag;
        logic               ovhit;
        logic [31:0]        ovx;
        logic [49:0]        t1, t2;
        logic [31:0]        c;
        logic [3:0][55:0]   wnum;
        logic [3:0][55:0]   wq;
        logic [3:0][16:0]   wrem;
        logic [7:0][63:0]   pr;
    } t_work;

    // base +/- mag, clamped to the signed 32-bit range
    function automatic logic [31:0] sat_add(logic signed [31:0] base, logic [35:0] mag,
                                            logic neg);
        logic signed [37:0] dlt;
        logic signed [37:0] sum;
        dlt = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        sum = $signed({{6{base[31]}}, base}) + dlt;
        if (sum > 38'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (sum < -38'sd2147483648) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

endpackage

// File: design/circle_pair_collision_resolve_core.sv
// ----------------------------------------------------------------------------
// Circle pair collision resolve core
// Elastic impulse along the contact normal plus partner-mass weighted
// position correction for one pair of circles per request.
// ----------------------------------------------------------------------------
//
//  Channel    | Dir | Handshake                   | Payload
//  -----------+-----+-----------------------------+------------------------------
//  s_axis     | in  | i_s_axis_tvalid/o_s_..ready | two circles, 350 bits in 352
//  m_axis     | out | o_m_axis_tvalid/i_m_..ready | eight Q16.16 words + status
//  cfg        | in  | i_cfg_valid/o_cfg_ready     | index 0 percent, 1 slop
//
//  One request enters every cycle while the pipeline advances; each is
//  presented on m_axis from the last stage register. The depth is set by
//  the 32-step square root, the 32-step normal divider and the 56-step
//  mass-weight divider, each cut into stages of four or eight steps.
//  The whole pipeline advances on one enable: it holds while the output
//  register is full and not taken, and s_axis is ready exactly when it advances.
//  Reset (synchronous, active low) clears the valid bits and loads the
//  register reset values; config is always ready.
//
module circle_pair_collision_resolve_core
    import cpcr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
    // first_radius, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    // second_mass, second_radius, 2 zero bits
    input  logic [351:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
    output logic [255:0] o_m_axis_tdata,
    // contact_status
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    localparam int NST = 32;
    // stage map
    localparam int K_SQ0 = 3;   // square root, 8 stages of 4 steps
    localparam int K_DV0 = 11;  // normal divide, 8 stages of 4 steps
    localparam int K_DOT = 19;
    localparam int K_SUM = 20;
    localparam int K_TM  = 21;
    localparam int K_CW  = 22;
    localparam int K_WD0 = 23;  // weight divide, 7 stages of 8 steps
    localparam int K_PR  = 30;
    localparam int K_OUT = 31;
    localparam logic [30:0] SLOP_RST =
        31'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    logic [15:0] r_pct;
    logic [30:0] r_slop;
    logic [NST-1:0] r_vld;
    t_work r_st [NST];
    t_work n_st [NST];
    logic w_adv;

    // advance when the output slot is empty or being taken
    assign w_adv           = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct  <= PCT_RST;
            r_slop <= SLOP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PCT:  r_pct  <= i_cfg_data[15:0];
                CFG_SLOP: r_slop <= i_cfg_data;
                default:  r_pct  <= r_pct;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_st
        if (k == 0) begin : g_prep
            // unpack, differences, weights
            always_comb begin
                logic [15:0] m1, m2;
                logic [30:0] r1, r2;
                m1 = i_s_axis_tdata[143:128];
                r1 = i_s_axis_tdata[174:144];
                m2 = i_s_axis_tdata[318:303];
                r2 = i_s_axis_tdata[349:319];
                n_st[k]     = '0;
                n_st[k].p1x = $signed(i_s_axis_tdata[31:0]);
                n_st[k].p1y = $signed(i_s_axis_tdata[63:32]);
                n_st[k].v1x = $signed(i_s_axis_tdata[95:64]);
                n_st[k].v1y = $signed(i_s_axis_tdata[127:96]);
                n_st[k].p2x = $signed(i_s_axis_tdata[206:175]);
                n_st[k].p2y = $signed(i_s_axis_tdata[238:207]);
                n_st[k].v2x = $signed(i_s_axis_tdata[270:239]);
                n_st[k].v2y = $signed(i_s_axis_tdata[302:271]);
                n_st[k].dx  = $signed({n_st[k].p1x[31], n_st[k].p1x})
                            - $signed({n_st[k].p2x[31], n_st[k].p2x});
                n_st[k].dy  = $signed({n_st[k].p1y[31], n_st[k].p1y})
                            - $signed({n_st[k].p2y[31], n_st[k].p2y});
                n_st[k].ax  = n_st[k].dx[32] ? 32'(-n_st[k].dx) : n_st[k].dx[31:0];
                n_st[k].ay  = n_st[k].dy[32] ? 32'(-n_st[k].dy) : n_st[k].dy[31:0];
                n_st[k].rvx = $signed({n_st[k].v1x[31], n_st[k].v1x})
                            - $signed({n_st[k].v2x[31], n_st[k].v2x});
                n_st[k].rvy = $signed({n_st[k].v1y[31], n_st[k].v1y})
                            - $signed({n_st[k].v2y[31], n_st[k].v2y});
                n_st[k].min_dist = {1'b0, r1} + {1'b0, r2};
                // each body moves by the partner's share; massless pair splits evenly
                if (m1 == 16'd0 && m2 == 16'd0) begin
                    n_st[k].w1   = 16'd1;
                    n_st[k].w2   = 16'd1;
                    n_st[k].wsum = 17'd2;
                end else begin
                    n_st[k].w1   = m2;
                    n_st[k].w2   = m1;
                    n_st[k].wsum = {1'b0, m1} + {1'b0, m2};
                end
            end
        end else if (k == 1) begin : g_sqr
            always_comb begin
                n_st[k]     = r_st[k-1];
                n_st[k].sx  = 64'(r_st[k-1].ax) * 64'(r_st[k-1].ax);
                n_st[k].sy  = 64'(r_st[k-1].ay) * 64'(r_st[k-1].ay);
                n_st[k].md2 = 64'(r_st[k-1].min_dist) * 64'(r_st[k-1].min_dist);
            end
        end else if (k == 2) begin : g_cmp
            // contact test, then seed the root and normal dividers
            always_comb begin
                logic [64:0] sum;
                n_st[k] = r_st[k-1];
                sum = {1'b0, r_st[k-1].sx} + {1'b0, r_st[k-1].sy};
                n_st[k].d2 = sum[63:0];
                if (sum[64] || sum[63:0] > r_st[k-1].md2) begin
                    n_st[k].status = ST_NONE;
                end else if (r_st[k-1].dx == 33'sd0 && r_st[k-1].dy == 33'sd0) begin
                    n_st[k].status = ST_COINCIDENT;
                end else begin
                    n_st[k].status = ST_RESOLVED;
                end
                n_st[k].srem  = '0;
                n_st[k].sroot = '0;
                // top bits of |d| << 28 preload the remainder; 32 steps remain
                n_st[k].xrem  = {4'b0000, r_st[k-1].ax[31:4]};
                n_st[k].xnum  = {r_st[k-1].ax[3:0], 28'd0};
                n_st[k].xq    = '0;
                n_st[k].yrem  = {4'b0000, r_st[k-1].ay[31:4]};
                n_st[k].ynum  = {r_st[k-1].ay[3:0], 28'd0};
                n_st[k].yq    = '0;
            end
        end else if (k < K_DV0) begin : g_sqrt
            // two radicand bits per step
            always_comb begin
                logic [35:0] r2;
                logic [33:0] tt;
                n_st[k] = r_st[k-1];
                for (int i = 0; i < 4; i++) begin
                    r2 = {n_st[k].srem, n_st[k].d2[63:62]};
                    tt = {n_st[k].sroot, 2'b01};
                    n_st[k].d2 = {n_st[k].d2[61:0], 2'b00};
                    if (r2 >= {2'b00, tt}) begin
                        n_st[k].srem  = 34'(r2 - {2'b00, tt});
                        n_st[k].sroot = {n_st[k].sroot[30:0], 1'b1};
                    end else begin
                        n_st[k].srem  = r2[33:0];
                        n_st[k].sroot = {n_st[k].sroot[30:0], 1'b0};
                    end
                end
            end
        end else if (k < K_DOT) begin : g_ndiv
            // restoring divide of |d| << 28 by the distance
            always_comb begin
                logic [32:0] rr;
                n_st[k] = r_st[k-1];
                for (int i = 0; i < 4; i++) begin
                    rr = {n_st[k].xrem, n_st[k].xnum[31]};
                    n_st[k].xnum = {n_st[k].xnum[30:0], 1'b0};
                    if (rr >= {1'b0, n_st[k].sroot}) begin
                        n_st[k].xrem = 32'(rr - {1'b0, n_st[k].sroot});
                        n_st[k].xq   = {n_st[k].xq[30:0], 1'b1};
                    end else begin
                        n_st[k].xrem = rr[31:0];
                        n_st[k].xq   = {n_st[k].xq[30:0], 1'b0};
                    end
                    rr = {n_st[k].yrem, n_st[k].ynum[31]};
                    n_st[k].ynum = {n_st[k].ynum[30:0], 1'b0};
                    if (rr >= {1'b0, n_st[k].sroot}) begin
                        n_st[k].yrem = 32'(rr - {1'b0, n_st[k].sroot});
                        n_st[k].yq   = {n_st[k].yq[30:0], 1'b1};
                    end else begin
                        n_st[k].yrem = rr[31:0];
                        n_st[k].yq   = {n_st[k].yq[30:0], 1'b0};
                    end
                end
            end
        end else if (k == K_DOT) begin : g_dot
            always_comb begin
                logic signed [29:0] nx, ny;
                n_st[k] = r_st[k-1];
                nx = r_st[k-1].dx[32] ? -$signed({1'b0, r_st[k-1].xq[28:0]})
                                      :  $signed({1'b0, r_st[k-1].xq[28:0]});
                ny = r_st[k-1].dy[32] ? -$signed({1'b0, r_st[k-1].yq[28:0]})
                                      :  $signed({1'b0, r_st[k-1].yq[28:0]});
                n_st[k].px = $signed(r_st[k-1].rvx) * nx;
                n_st[k].py = $signed(r_st[k-1].rvy) * ny;
            end
        end else if (k == K_SUM) begin : g_sum
            // approach test, impulse magnitude, overlap beyond slop
            always_comb begin
                logic signed [63:0] s;
                logic [63:0] smag;
                logic [31:0] ovl;
                n_st[k] = r_st[k-1];
                s = 64'(r_st[k-1].px) + 64'(r_st[k-1].py);
                smag = s[63] ? 64'(-s) : 64'(s);
                n_st[k].dmag = smag[61:28];
                if (r_st[k-1].status == ST_RESOLVED && !s[63] && s != 64'sd0) begin
                    n_st[k].status = ST_SEPARATING;
                end
                ovl = r_st[k-1].min_dist - r_st[k-1].sroot;
                n_st[k].ovhit = ovl > {1'b0, r_slop};
                n_st[k].ovx   = ovl - {1'b0, r_slop};
            end
        end else if (k == K_TM) begin : g_tm
            always_comb begin
                logic [47:0] cp;
                n_st[k] = r_st[k-1];
                n_st[k].t1 = 50'(r_st[k-1].dmag) * 50'(r_st[k-1].w1);
                n_st[k].t2 = 50'(r_st[k-1].dmag) * 50'(r_st[k-1].w2);
                cp = 48'(r_st[k-1].ovx) * 48'(r_pct);
                n_st[k].c = cp[47:PCT_BITS];
            end
        end else if (k == K_CW) begin : g_cw
            // seed the four weight dividers
            always_comb begin
                n_st[k] = r_st[k-1];
                n_st[k].wnum[0] = {5'd0, r_st[k-1].t1, 1'b0};
                n_st[k].wnum[1] = {5'd0, r_st[k-1].t2, 1'b0};
                n_st[k].wnum[2] = 56'(r_st[k-1].c) * 56'(r_st[k-1].w1);
                n_st[k].wnum[3] = 56'(r_st[k-1].c) * 56'(r_st[k-1].w2);
                n_st[k].wq   = '0;
                n_st[k].wrem = '0;
            end
        end else if (k < K_PR) begin : g_wdiv
            always_comb begin
                logic [17:0] rr;
                n_st[k] = r_st[k-1];
                for (int j = 0; j < 4; j++) begin
                    for (int i = 0; i < 8; i++) begin
                        rr = {n_st[k].wrem[j], n_st[k].wnum[j][55]};
                        n_st[k].wnum[j] = {n_st[k].wnum[j][54:0], 1'b0};
                        if (rr >= {1'b0, n_st[k].wsum}) begin
                            n_st[k].wrem[j] = 17'(rr - {1'b0, n_st[k].wsum});
                            n_st[k].wq[j]   = {n_st[k].wq[j][54:0], 1'b1};
                        end else begin
                            n_st[k].wrem[j] = rr[16:0];
                            n_st[k].wq[j]   = {n_st[k].wq[j][54:0], 1'b0};
                        end
                    end
                end
            end
        end else if (k == K_PR) begin : g_prod
            // shares times normal magnitudes
            always_comb begin
                n_st[k] = r_st[k-1];
                for (int j = 0; j < 4; j++) begin
                    n_st[k].pr[2*j]   = 64'(r_st[k-1].wq[j][34:0]) * 64'(r_st[k-1].xq[28:0]);
                    n_st[k].pr[2*j+1] = 64'(r_st[k-1].wq[j][34:0]) * 64'(r_st[k-1].yq[28:0]);
                end
            end
        end else begin : g_out
            // apply, restore sign and saturate
            always_comb begin
                logic vel, pos, nxs, nys;
                n_st[k] = r_st[k-1];
                vel = r_st[k-1].status == ST_RESOLVED;
                pos = vel && r_st[k-1].ovhit;
                nxs = r_st[k-1].dx[32];
                nys = r_st[k-1].dy[32];
                if (vel) begin
                    n_st[k].v1x = sat_add(r_st[k-1].v1x, r_st[k-1].pr[0][63:NORM_BITS], nxs);
                    n_st[k].v1y = sat_add(r_st[k-1].v1y, r_st[k-1].pr[1][63:NORM_BITS], nys);
                    n_st[k].v2x = sat_add(r_st[k-1].v2x, r_st[k-1].pr[2][63:NORM_BITS], !nxs);
                    n_st[k].v2y = sat_add(r_st[k-1].v2y, r_st[k-1].pr[3][63:NORM_BITS], !nys);
                end
                if (pos) begin
                    n_st[k].p1x = sat_add(r_st[k-1].p1x, r_st[k-1].pr[4][63:NORM_BITS], nxs);
                    n_st[k].p1y = sat_add(r_st[k-1].p1y, r_st[k-1].pr[5][63:NORM_BITS], nys);
                    n_st[k].p2x = sat_add(r_st[k-1].p2x, r_st[k-1].pr[6][63:NORM_BITS], !nxs);
                    n_st[k].p2y = sat_add(r_st[k-1].p2y, r_st[k-1].pr[7][63:NORM_BITS], !nys);
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {r_st[K_OUT].v2y, r_st[K_OUT].v2x, r_st[K_OUT].p2y,
                              r_st[K_OUT].p2x, r_st[K_OUT].v1y, r_st[K_OUT].v1x,
                              r_st[K_OUT].p1y, r_st[K_OUT].p1x};
    assign o_m_axis_tuser  = r_st[K_OUT].status;

endmodule

// File: design/cpcr_checker.sv
// ----------------------------------------------------------------------------
// Circle pair collision resolve: port checker
// Watches the handshakes of the core and the stall behaviour of its output.
// ----------------------------------------------------------------------------
module cpcr_checker
    import cpcr_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [255:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // the input side follows the output slot
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not track output slot");

    // reset drops every result
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind circle_pair_collision_resolve_core cpcr_checker u_cpcr_checker (.*);

// File: test/tb_circle_pair_collision_resolve_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair collision resolve core testbench
// Drives circle pairs with random gaps and output stalls, predicts each
// resolved pair in SystemVerilog and compares every word and the status in
// order. Both registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolve_core
    import cpcr_pkg::*;
();

    localparam int FRAC = 16;
    localparam int NBITS = 28;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [30:0] r2;
        logic [15:0] m2;
        logic signed [31:0] v2y, v2x, p2y, p2x;
        logic [30:0] r1;
        logic [15:0] m1;
        logic signed [31:0] v1y, v1x, p1y, p1x;
    } t_pair;

    typedef struct packed {
        t_status st;
        logic [255:0] words;
    } t_outcome;

    // Scoreboard: holds the register copy and the queue of predicted outcomes
    class pair_scoreboard;
        logic [15:0] pct;
        logic [30:0] slop;
        t_outcome pending[$];
        int errors;

        function new();
            pct = PCT_RST;
            slop = 31'd655;
            errors = 0;
        endfunction

        static function logic [127:0] mag(logic signed [127:0] v);
            return v < 0 ? -v : v;
        endfunction

        static function logic signed [127:0] scale_n(logic [127:0] m,
                                                      logic signed [127:0] n);
            logic [127:0] p;
            p = (m * mag(n)) >> NBITS;
            return n < 0 ? -$signed(p) : $signed(p);
        endfunction

        static function logic [31:0] clamp(logic signed [127:0] v);
            if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -128'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        // note an accepted request: work out the resolved pair
        function void note_pair(t_pair q);
            logic signed [127:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
            logic signed [127:0] dx, dy, nx, ny, s;
            logic [127:0] d2, md2, md, root, rem, bitv, dmag, w1, w2, ws;
            logic [127:0] k1, k2, ov, c, c1, c2;
            t_outcome o;
            p1x = q.p1x; p1y = q.p1y; v1x = q.v1x; v1y = q.v1y;
            p2x = q.p2x; p2y = q.p2y; v2x = q.v2x; v2y = q.v2y;
            o.st = ST_NONE;
            dx = p1x - p2x;
            dy = p1y - p2y;
            d2 = mag(dx) * mag(dx) + mag(dy) * mag(dy);
            md = {97'd0, q.r1} + {97'd0, q.r2};
            md2 = md * md;
            if (d2 < (128'd1 << 64) && d2 <= md2) begin
                if (dx == 0 && dy == 0) begin
                    o.st = ST_COINCIDENT;
                end else begin
                    // floor square root, bit by bit
                    rem = d2; root = 0; bitv = 128'd1 << 62;
                    while (bitv > rem) bitv >>= 2;
                    while (bitv != 0) begin
                        if (rem >= root + bitv) begin
                            rem -= root + bitv;
                            root = (root >> 1) + bitv;
                        end else begin
                            root >>= 1;
                        end
                        bitv >>= 2;
                    end
                    nx = $signed((mag(dx) << NBITS) / root);
                    ny = $signed((mag(dy) << NBITS) / root);
                    if (dx < 0) nx = -nx;
                    if (dy < 0) ny = -ny;
                    s = (v1x - v2x) * nx + (v1y - v2y) * ny;
                    if (s > 0) begin
                        o.st = ST_SEPARATING;
                    end else begin
                        dmag = mag(s) >> NBITS;
                        w1 = q.m2; w2 = q.m1; ws = w1 + w2;
                        if (ws == 0) begin
                            w1 = 1; w2 = 1; ws = 2;
                        end
                        k1 = (2 * dmag * w1) / ws;
                        k2 = (2 * dmag * w2) / ws;
                        v1x += scale_n(k1, nx);
                        v1y += scale_n(k1, ny);
                        v2x -= scale_n(k2, nx);
                        v2y -= scale_n(k2, ny);
                        ov = md - root;
                        if (ov > slop) begin
                            c = ((ov - slop) * pct) >> PCT_BITS;
                            c1 = (c * w1) / ws;
                            c2 = (c * w2) / ws;
                            p1x += scale_n(c1, nx);
                            p1y += scale_n(c1, ny);
                            p2x -= scale_n(c2, nx);
                            p2y -= scale_n(c2, ny);
                        end
                        o.st = ST_RESOLVED;
                    end
                end
            end
            o.words = {clamp(v2y), clamp(v2x), clamp(p2y), clamp(p2x),
                       clamp(v1y), clamp(v1x), clamp(p1y), clamp(p1x)};
            pending.push_back(o);
        endfunction

        // check one accepted result against the oldest prediction
        function void check_result(logic [255:0] words, logic [1:0] st);
            t_outcome e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result words=%h status=%0d", $time, words, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (words[32*i +: 32] !== e.words[32*i +: 32]) begin
                    $display("%0t: word %0d expected %h actual %h", $time, i,
                             e.words[32*i +: 32], words[32*i +: 32]);
                    errors++;
                end
            end
            if (st !== e.st) begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // two circles from first_pos_x up, 2 zero bits on top
    logic [351:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // eight result words, new_first_pos_x lowest
    logic [255:0] o_m_axis_tdata;
    // contact_status
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 1'b0;
    logic [30:0]  i_cfg_data = '0;

    pair_scoreboard sb = new();
    int  idle_cycles;
    bit  stall_long;

    circle_pair_collision_resolve_core #(.FRAC_BITS(FRAC)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random back-pressure, check on every taken result
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            g = stall_long ? pick_gap() : 0;
            if (g == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    // watchdog: count cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_pair(t_pair q);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {2'b00, q};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pair(q);
    endtask

    // valid drops after each write and stays low before the task returns, keeping back-to-back writes apart
    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PCT) sb.pct = val[15:0];
        else sb.slop = val;
        @(posedge i_clk);
    endtask

    // hold until every prediction has been matched, then let the pipe drain
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // pair near contact: second centre a small step from the first
    function automatic t_pair contact_pair();
        t_pair q;
        int span;
        span = 1 << $urandom_range(8, 22);
        q.p1x = $urandom_range(0, 1) ? rnd_word() : $signed($urandom_range(0, 1 << 24))
                - (1 << 23);
        q.p1y = $urandom_range(0, 1) ? rnd_word() : $signed($urandom_range(0, 1 << 24))
                - (1 << 23);
        q.p2x = q.p1x + $signed($urandom_range(0, 2 * span)) - span;
        q.p2y = q.p1y + $signed($urandom_range(0, 2 * span)) - span;
        q.v1x = $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 1 << 22))
                - (1 << 21);
        q.v1y = $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 1 << 22))
                - (1 << 21);
        q.v2x = $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 1 << 22))
                - (1 << 21);
        q.v2y = $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 1 << 22))
                - (1 << 21);
        q.m1 = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(1, 65535));
        q.m2 = $urandom_range(0, 7) == 0 ? 16'h0001 : 16'($urandom_range(1, 65535));
        q.r1 = $urandom_range(0, 9) == 0 ? 31'($urandom) : 31'($urandom_range(0, span));
        q.r2 = $urandom_range(0, 9) == 0 ? 31'($urandom) : 31'($urandom_range(0, span));
        return q;
    endfunction

    function automatic t_pair noise_pair();
        t_pair q;
        logic [351:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[349:0];
        if (q.m1 == 0) q.m1 = 1;
        if (q.m2 == 0) q.m2 = 1;
        return q;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_pair($urandom_range(0, 4) == 0 ? noise_pair() : contact_pair());
    endtask

    initial begin
        t_pair q;
        stall_long = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident, head-on approach, separating, no contact, extremes
        q = '0; q.m1 = 16'h0100; q.m2 = 16'h0100; q.r1 = 31'h10000; q.r2 = 31'h10000;
        send_pair(q);
        q.p1x = 32'sh18000; q.v1x = -32'sh20000;
        send_pair(q);
        q.v1x = 32'sh20000;
        send_pair(q);
        q.v1x = 0;                               // zero dot counts as approaching
        send_pair(q);
        q.p1x = 32'sh1FFFF;                      // overlap inside the slop
        q.v1x = -32'sh10000;
        send_pair(q);
        q.p1x = 32'sh50000;
        send_pair(q);
        q.p1x = 32'sh7FFF_FFFF; q.p2x = 32'sh8000_0000;
        q.r1 = 31'h7FFF_FFFF; q.r2 = 31'h7FFF_FFFF;
        q.v1x = 32'sh8000_0000; q.v2x = 32'sh7FFF_FFFF;
        q.m1 = 16'hFFFF; q.m2 = 16'h0001;
        send_pair(q);
        q.p1y = 32'sh7FFF_FFFF; q.p2y = 32'sh8000_0000;
        q.v1y = 32'sh8000_0000; q.v2y = 32'sh7FFF_FFFF;
        send_pair(q);
        q.p1x = 32'sh7FFF_0000; q.p2x = 32'sh7FFE_0000; q.p1y = 0; q.p2y = 0;
        q.v1x = 32'sh8000_0000; q.v2x = 32'sh7FFF_FFFF; q.r1 = 31'h40000; q.r2 = 0;
        send_pair(q);
        for (int i = 0; i < 12; i++) send_pair(contact_pair());
        drain();

        // several register settings, extremes among them
        write_reg(CFG_PCT, 31'd65535);
        write_reg(CFG_SLOP, 31'd0);
        stall_long = 1'b1;
        random_phase(220);
        drain();
        write_reg(CFG_PCT, 31'd0);
        write_reg(CFG_SLOP, 31'h7FFF_FFFF);
        random_phase(180);
        drain();
        write_reg(CFG_PCT, 31'($urandom_range(0, 65535)));
        write_reg(CFG_SLOP, 31'($urandom_range(0, 1 << 20)));
        stall_long = 1'b0;
        random_phase(200);
        drain();
        write_reg(CFG_PCT, 31'd52429);
        write_reg(CFG_SLOP, 31'd655);
        stall_long = 1'b1;
        random_phase(280);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/cpcr_pkg.sv
design/circle_pair_collision_resolve_core.sv
design/cpcr_checker.sv
test/tb_circle_pair_collision_resolve_core.sv
